// ===== rtl/core/olist_pkg.sv =====
// Shared constants, types and the control store of the ordered list sequencer.
`timescale 1ns / 1ps

package olist_pkg;

  localparam int CAPACITY = 64;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 7;
  localparam int STS_W    = 3;
  localparam int UPC_W    = 5;

  typedef logic [STS_W-1:0]  status_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [UPC_W-1:0]  upc_t;

  // Result status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_EMPTY    = 3'd1;
  localparam status_t ST_FULL     = 3'd2;
  localparam status_t ST_BADPOS   = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

  // Command codes
  localparam func_t FN_LOAD    = 3'd0;
  localparam func_t FN_DISPLAY = 3'd1;
  localparam func_t FN_INSERT  = 3'd2;
  localparam func_t FN_DELETE  = 3'd3;
  localparam func_t FN_SEARCH  = 3'd4;

  // Control store addresses
  localparam upc_t UA_IDLE    = 5'd0;
  localparam upc_t UA_LD_CHK  = 5'd1;
  localparam upc_t UA_LD_WR   = 5'd2;
  localparam upc_t UA_DS_CHK  = 5'd3;
  localparam upc_t UA_DS_RD   = 5'd4;
  localparam upc_t UA_DS_OUT  = 5'd5;
  localparam upc_t UA_IN_FULL = 5'd6;
  localparam upc_t UA_IN_POS  = 5'd7;
  localparam upc_t UA_IN_RD   = 5'd8;
  localparam upc_t UA_IN_WR   = 5'd9;
  localparam upc_t UA_IN_PUT  = 5'd10;
  localparam upc_t UA_DL_CHK  = 5'd11;
  localparam upc_t UA_DL_POS  = 5'd12;
  localparam upc_t UA_DL_RD   = 5'd13;
  localparam upc_t UA_DL_WR   = 5'd14;
  localparam upc_t UA_DL_DEC  = 5'd15;
  localparam upc_t UA_SR_CHK  = 5'd16;
  localparam upc_t UA_SR_RD   = 5'd17;
  localparam upc_t UA_SR_CMP  = 5'd18;
  localparam upc_t UA_SR_NXT  = 5'd19;
  localparam upc_t UA_E_OK    = 5'd20;
  localparam upc_t UA_E_EMPTY = 5'd21;
  localparam upc_t UA_E_FULL  = 5'd22;
  localparam upc_t UA_E_BAD   = 5'd23;
  localparam upc_t UA_E_NOTF  = 5'd24;
  localparam upc_t UA_E_FOUND = 5'd25;

  // Datapath actions
  typedef enum logic [4:0] {
    A_NONE,
    A_LOADCLR,    // empty the list when first is set
    A_APPEND,     // store value at the tail, grow length
    A_IDXCLR,     // index to zero
    A_IDXLEN,     // index to length
    A_IDXPOS,     // index to position minus one
    A_IDXINC,     // index up by one
    A_RDIDX,      // read entry at index
    A_RDDEC,      // read entry below index
    A_RDINC,      // read entry above index
    A_WRUP,       // write read data at index, index down
    A_WRDN,       // write read data at index, index up
    A_INSERT,     // store value at position, grow length
    A_LENDEC,     // shrink length
    A_EMIT,       // emit status-only result
    A_EMITELEM,   // emit displayed element, index up
    A_EMITFOUND   // emit search hit at index
  } act_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_DISPATCH,
    C_ALWAYS,
    C_LOADFULL,
    C_FULL,
    C_EMPTY,
    C_BADINS,
    C_BADDEL,
    C_IDXLTPOS,
    C_SHIFTEND,
    C_IDXLTLEN,
    C_MATCH,
    C_LASTELEM
  } cnd_t;

  typedef struct packed {
    act_t    act;
    cnd_t    cnd;
    status_t sts;
    upc_t    on_true;
    upc_t    on_false;
  } uword_t;

  function automatic uword_t uw(act_t a, cnd_t c, status_t s, upc_t t, upc_t f);
    uword_t w;
    w.act      = a;
    w.cnd      = c;
    w.sts      = s;
    w.on_true  = t;
    w.on_false = f;
    return w;
  endfunction

  // Control store
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      UA_IDLE:    w = uw(A_NONE,      C_DISPATCH, ST_OK, UA_IDLE,    UA_IDLE);
      UA_LD_CHK:  w = uw(A_LOADCLR,   C_LOADFULL, ST_OK, UA_E_FULL,  UA_LD_WR);
      UA_LD_WR:   w = uw(A_APPEND,    C_ALWAYS,   ST_OK, UA_E_OK,    UA_E_OK);
      UA_DS_CHK:  w = uw(A_IDXCLR,    C_EMPTY,    ST_OK, UA_E_EMPTY, UA_DS_RD);
      UA_DS_RD:   w = uw(A_RDIDX,     C_ALWAYS,   ST_OK, UA_DS_OUT,  UA_DS_OUT);
      UA_DS_OUT:  w = uw(A_EMITELEM,  C_LASTELEM, ST_OK, UA_IDLE,    UA_DS_RD);
      UA_IN_FULL: w = uw(A_IDXLEN,    C_FULL,     ST_OK, UA_E_FULL,  UA_IN_POS);
      UA_IN_POS:  w = uw(A_NONE,      C_BADINS,   ST_OK, UA_E_BAD,   UA_IN_RD);
      UA_IN_RD:   w = uw(A_RDDEC,     C_IDXLTPOS, ST_OK, UA_IN_PUT,  UA_IN_WR);
      UA_IN_WR:   w = uw(A_WRUP,      C_ALWAYS,   ST_OK, UA_IN_RD,   UA_IN_RD);
      UA_IN_PUT:  w = uw(A_INSERT,    C_ALWAYS,   ST_OK, UA_E_OK,    UA_E_OK);
      UA_DL_CHK:  w = uw(A_IDXPOS,    C_EMPTY,    ST_OK, UA_E_EMPTY, UA_DL_POS);
      UA_DL_POS:  w = uw(A_NONE,      C_BADDEL,   ST_OK, UA_E_BAD,   UA_DL_RD);
      UA_DL_RD:   w = uw(A_RDINC,     C_SHIFTEND, ST_OK, UA_DL_DEC,  UA_DL_WR);
      UA_DL_WR:   w = uw(A_WRDN,      C_ALWAYS,   ST_OK, UA_DL_RD,   UA_DL_RD);
      UA_DL_DEC:  w = uw(A_LENDEC,    C_ALWAYS,   ST_OK, UA_E_OK,    UA_E_OK);
      UA_SR_CHK:  w = uw(A_IDXCLR,    C_EMPTY,    ST_OK, UA_E_EMPTY, UA_SR_RD);
      UA_SR_RD:   w = uw(A_RDIDX,     C_ALWAYS,   ST_OK, UA_SR_CMP,  UA_SR_CMP);
      UA_SR_CMP:  w = uw(A_IDXINC,    C_MATCH,    ST_OK, UA_E_FOUND, UA_SR_NXT);
      UA_SR_NXT:  w = uw(A_NONE,      C_IDXLTLEN, ST_OK, UA_SR_RD,   UA_E_NOTF);
      UA_E_OK:    w = uw(A_EMIT,      C_ALWAYS,   ST_OK,       UA_IDLE, UA_IDLE);
      UA_E_EMPTY: w = uw(A_EMIT,      C_ALWAYS,   ST_EMPTY,    UA_IDLE, UA_IDLE);
      UA_E_FULL:  w = uw(A_EMIT,      C_ALWAYS,   ST_FULL,     UA_IDLE, UA_IDLE);
      UA_E_BAD:   w = uw(A_EMIT,      C_ALWAYS,   ST_BADPOS,   UA_IDLE, UA_IDLE);
      UA_E_NOTF:  w = uw(A_EMIT,      C_ALWAYS,   ST_NOTFOUND, UA_IDLE, UA_IDLE);
      UA_E_FOUND: w = uw(A_EMITFOUND, C_ALWAYS,   ST_OK,       UA_IDLE, UA_IDLE);
      default:    w = uw(A_NONE,      C_ALWAYS,   ST_OK,       UA_IDLE, UA_IDLE);
    endcase
    return w;
  endfunction

  // Entry point of each command routine; unused codes answer plain ok
  function automatic upc_t dispatch(func_t f);
    upc_t a;
    unique case (f)
      FN_LOAD:    a = UA_LD_CHK;
      FN_DISPLAY: a = UA_DS_CHK;
      FN_INSERT:  a = UA_IN_FULL;
      FN_DELETE:  a = UA_DL_CHK;
      FN_SEARCH:  a = UA_SR_CHK;
      default:    a = UA_E_OK;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/olist_if.sv =====
// Command and result channel interfaces of the ordered list block.
`timescale 1ns / 1ps

interface olist_req_if import olist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [WORD_W-1:0] value;
  logic [POS_W-1:0]         position;
  logic                     first;

  modport source (output valid, func, value, position, first, input ready);
  modport sink   (input valid, func, value, position, first, output ready);
endinterface

interface olist_rsp_if import olist_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STS_W-1:0]         status;
  logic signed [WORD_W-1:0] element;
  logic [POS_W-1:0]         found_at;
  logic [POS_W-1:0]         length;
  logic                     last;

  modport source (output valid, status, element, found_at, length, last, input ready);
  modport sink   (input valid, status, element, found_at, length, last, output ready);
endinterface

// ===== rtl/core/ordered_list_insert_delete_search.sv =====
// Ordered list with load, display, insert, delete and search, run by a microcoded sequencer.
// Insert and delete shift the entries behind the position one at a time, and search reads
// and compares one entry at a time until a hit or the end of the list. Empty, full and
// bad-position cases answer with a status only; display gives one result per element.
// A held result stalls the sequencer on its emit step.
// One command at a time. Reset (rst, synchronous) empties the list; store contents stay.
`timescale 1ns / 1ps

module ordered_list_insert_delete_search import olist_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  olist_req_if.sink   req,
  olist_rsp_if.source rsp
);

  // Sequencer and datapath registers
  upc_t                     upc, upc_next;
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         idx;
  logic signed [WORD_W-1:0] cmd_value;
  logic [POS_W-1:0]         cmd_pos;
  logic                     cmd_first;
  logic [WORD_W-1:0]        rd_data;
  logic [WORD_W-1:0]        mem [CAPACITY];

  uword_t           w;
  logic             out_free;
  logic             is_emit;
  logic             stall;
  logic             cond;
  logic             accept;
  logic [POS_W-1:0] pos_m1;
  logic [LEN_W:0]   len_p1;
  logic [LEN_W:0]   idx_p1;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;

  // Decode the current control word
  always_comb begin
    w        = ucode(upc);
    out_free = !rsp.valid || rsp.ready;
    is_emit  = (w.act == A_EMIT) || (w.act == A_EMITELEM) || (w.act == A_EMITFOUND);
    stall    = is_emit && !out_free;
    pos_m1   = cmd_pos - POS_W'(1);
    len_p1   = {1'b0, len} + (LEN_W+1)'(1);
    idx_p1   = {1'b0, idx} + (LEN_W+1)'(1);
  end

  assign req.ready = (w.cnd == C_DISPATCH);
  assign accept    = req.valid && req.ready;

  // Evaluate the jump condition
  always_comb begin
    unique case (w.cnd)
      C_DISPATCH: cond = 1'b0;
      C_ALWAYS:   cond = 1'b1;
      C_LOADFULL: cond = !cmd_first && (len >= LEN_W'(CAPACITY));
      C_FULL:     cond = (len >= LEN_W'(CAPACITY));
      C_EMPTY:    cond = (len == '0);
      C_BADINS:   cond = (cmd_pos == '0) || ((LEN_W+1)'(cmd_pos) > len_p1);
      C_BADDEL:   cond = (cmd_pos == '0) || ((LEN_W+1)'(cmd_pos) > {1'b0, len});
      C_IDXLTPOS: cond = ({1'b0, idx} < (LEN_W+1)'(cmd_pos));
      C_SHIFTEND: cond = (idx_p1 >= {1'b0, len});
      C_IDXLTLEN: cond = (idx < len);
      C_MATCH:    cond = (rd_data == cmd_value);
      C_LASTELEM: cond = (idx_p1 == {1'b0, len});
      default:    cond = 1'b1;
    endcase
  end

  // Select the next step
  always_comb begin
    if (w.cnd == C_DISPATCH) begin
      upc_next = req.valid ? dispatch(req.func) : UA_IDLE;
    end else if (stall) begin
      upc_next = upc;
    end else begin
      upc_next = cond ? w.on_true : w.on_false;
    end
  end

  // Store port controls
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[PTR_W-1:0];
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = idx[PTR_W-1:0];
    unique case (w.act)
      A_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = len[PTR_W-1:0];
        wr_data = cmd_value;
      end
      A_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = pos_m1[PTR_W-1:0];
        wr_data = cmd_value;
      end
      A_WRUP, A_WRDN: wr_en = 1'b1;
      A_RDIDX:        rd_en = 1'b1;
      A_RDDEC: begin
        rd_en   = 1'b1;
        rd_addr = idx[PTR_W-1:0] - PTR_W'(1);
      end
      A_RDINC: begin
        rd_en   = 1'b1;
        rd_addr = idx[PTR_W-1:0] + PTR_W'(1);
      end
      default: ;
    endcase
  end

  // Element store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Latch the command on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_value <= req.value;
      cmd_pos   <= req.position;
      cmd_first <= req.first;
    end
  end

  // Sequencer, length and index
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_IDLE;
      len <= '0;
      idx <= '0;
    end else begin
      upc <= upc_next;
      if (!stall) begin
        unique case (w.act)
          A_LOADCLR:   if (cmd_first) len <= '0;
          A_APPEND:    len <= len + LEN_W'(1);
          A_INSERT:    len <= len + LEN_W'(1);
          A_LENDEC:    len <= len - LEN_W'(1);
          A_IDXCLR:    idx <= '0;
          A_IDXLEN:    idx <= len;
          A_IDXPOS:    idx <= LEN_W'(pos_m1);
          A_IDXINC:    idx <= idx + LEN_W'(1);
          A_WRUP:      idx <= idx - LEN_W'(1);
          A_WRDN:      idx <= idx + LEN_W'(1);
          A_EMITELEM:  idx <= idx + LEN_W'(1);
          default: ;
        endcase
      end
    end
  end

  // Output register: hold until taken, load on emit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (is_emit && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_emit && out_free) begin
      rsp.status <= w.sts;
      rsp.length <= POS_W'(len);
      unique case (w.act)
        A_EMITELEM: begin
          rsp.element  <= rd_data;
          rsp.found_at <= POS_W'(idx_p1);
          rsp.last     <= (idx_p1 == {1'b0, len});
        end
        A_EMITFOUND: begin
          rsp.element  <= '0;
          rsp.found_at <= POS_W'(idx);
          rsp.last     <= 1'b1;
        end
        default: begin
          rsp.element  <= '0;
          rsp.found_at <= '0;
          rsp.last     <= 1'b1;
        end
      endcase
    end
  end

endmodule
